>>> design/tce_pkg.sv
// Shared opcodes, field widths and control types of the tiny CPU execute unit.
// Depends on nothing; every other file of the block but tce_ram imports it.
`default_nettype none

package tce_pkg;

	// Fixed widths of the instruction and result words
	localparam int OP_W   = 4;
	localparam int IDX_W  = 4;
	localparam int WORD_W = 32;
	localparam int NPC_W  = 16;
	localparam int ADDR_W = 8;

	// Opcodes
	localparam logic [OP_W-1:0] OP_LD_DIR = 4'd0;
	localparam logic [OP_W-1:0] OP_ST_DIR = 4'd1;
	localparam logic [OP_W-1:0] OP_ST_IND = 4'd2;
	localparam logic [OP_W-1:0] OP_LD_IMM = 4'd3;
	localparam logic [OP_W-1:0] OP_COPY   = 4'd4;
	localparam logic [OP_W-1:0] OP_LD_IND = 4'd5;
	localparam logic [OP_W-1:0] OP_ADD    = 4'd6;
	localparam logic [OP_W-1:0] OP_SUB    = 4'd7;
	localparam logic [OP_W-1:0] OP_MUL    = 4'd8;
	localparam logic [OP_W-1:0] OP_JZ     = 4'd9;

	// Status of one executed instruction
	typedef struct packed {
		logic illegal;
		logic reg_wr;
		logic mem_wr;
	} exec_flags_t;

endpackage

`default_nettype wire

>>> design/tce_if.sv
// Valid/ready channels of the execute unit: instruction words in, result words out.
// Depends on tce_pkg for the field widths.
`default_nettype none

interface tce_cmd_if;
	import tce_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic [IDX_W-1:0]         first_reg;
	logic signed [WORD_W-1:0] second_operand;

	modport source (output valid, op, first_reg, second_operand, input ready);
	modport sink   (input valid, op, first_reg, second_operand, output ready);
endinterface

interface tce_res_if;
	import tce_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [NPC_W-1:0]         next_pc;
	logic                     illegal;
	logic                     reg_write;
	logic [IDX_W-1:0]         reg_target;
	logic signed [WORD_W-1:0] reg_data;
	logic                     mem_write;
	logic [ADDR_W-1:0]        mem_address;
	logic signed [WORD_W-1:0] mem_data;

	modport source (output valid, next_pc, illegal, reg_write, reg_target, reg_data,
		mem_write, mem_address, mem_data, input ready);
	modport sink   (input valid, next_pc, illegal, reg_write, reg_target, reg_data,
		mem_write, mem_address, mem_data, output ready);
endinterface

`default_nettype wire

>>> design/tiny_cpu_execute_unit.sv
// Execute unit of a small register machine: decoded instruction word in, result word out.
// The instruction is held in the execute stage, then its result word is registered in the
// output register; an indirect load's second data-memory read follows the register read.
// Throughput: one per cycle while the result word is taken; an indirect load holds off the next.
// Reset (asynchronous): PC cleared, register and memory valid bits cleared so all read zero.
// Depends on tce_pkg, tce_if, tce_ram and tce_alu.
`default_nettype none

module tiny_cpu_execute_unit #(
	parameter int REG_COUNT = 16,
	parameter int MEM_WORDS = 256,
	parameter int DATA_BITS = 32,
	parameter int PC_BITS   = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tce_cmd_if.sink   cmd,
	tce_res_if.source res
);
	import tce_pkg::*;

	localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int MADR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	// Handshake and stage control
	logic cmd_fire;
	logic out_free;
	logic s1_step;
	logic s1_done;

	// Execute stage
	logic              v_s1;
	logic              ph_s1;
	logic [OP_W-1:0]   op_s1;
	logic [IDX_W-1:0]  rd_s1;
	logic [IDX_W-1:0]  srcb_s1;
	logic [WORD_W-1:0] so_s1;
	logic [ADDR_W-1:0] maddr_s1;

	logic [IDX_W-1:0]     srcb_in;
	logic [ADDR_W-1:0]    m_rd_addr;
	logic [DATA_BITS-1:0] ram_a;
	logic [DATA_BITS-1:0] ram_b;
	logic [DATA_BITS-1:0] ram_m;
	logic [DATA_BITS-1:0] opa;
	logic [DATA_BITS-1:0] opb;
	logic [DATA_BITS-1:0] mem_val;

	// Architectural state around the memories
	logic [PC_BITS-1:0]   pc_q;
	logic [REG_COUNT-1:0] rvalid_q;
	logic [MEM_WORDS-1:0] mvalid_q;
	logic                 fwr_v_q;
	logic [RIDX_W-1:0]    fwr_idx_q;
	logic [DATA_BITS-1:0] fwr_data_q;
	logic                 fwm_v_q;
	logic [MADR_W-1:0]    fwm_addr_q;
	logic [DATA_BITS-1:0] fwm_data_q;

	// Datapath results
	exec_flags_t          flags;
	logic [DATA_BITS-1:0] alu_reg_data;
	logic [ADDR_W-1:0]    alu_mem_addr;
	logic [DATA_BITS-1:0] alu_mem_data;
	logic [PC_BITS-1:0]   alu_next_pc;
	logic                 reg_we;
	logic                 mem_we;

	// Output register
	logic              out_v_q;
	logic [NPC_W-1:0]  npc_q;
	logic              ill_q;
	logic              rwr_q;
	logic [IDX_W-1:0]  rtgt_q;
	logic [WORD_W-1:0] rdat_q;
	logic              mwr_q;
	logic [ADDR_W-1:0] madr_q;
	logic [WORD_W-1:0] mdat_q;

	// Advance: an indirect load takes an extra execute step for its data-memory read
	assign out_free  = !out_v_q || res.ready;
	assign s1_step   = v_s1 && (op_s1 == OP_LD_IND) && !ph_s1;
	assign s1_done   = v_s1 && !s1_step && out_free;
	assign cmd.ready = !v_s1 || s1_done;
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Second register port: indirect stores and indirect loads use the low nibble
	assign srcb_in = (cmd.op == OP_ST_IND || cmd.op == OP_LD_IND) ?
		cmd.second_operand[3:0] : cmd.second_operand[7:4];

	// Data memory read: direct address on entry, register-held address on the extra step
	assign m_rd_addr = s1_step ? opb[ADDR_W-1:0] : cmd.second_operand[ADDR_W-1:0];

	assign reg_we = s1_done && flags.reg_wr;
	assign mem_we = s1_done && flags.mem_wr;

	// Register file, one copy per read port
	tce_ram #(.WIDTH(DATA_BITS), .DEPTH(REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (reg_we),
		.waddr (rd_s1[RIDX_W-1:0]),
		.wdata (alu_reg_data),
		.re    (cmd_fire),
		.raddr (cmd.first_reg[RIDX_W-1:0]),
		.rdata (ram_a)
	);

	tce_ram #(.WIDTH(DATA_BITS), .DEPTH(REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (reg_we),
		.waddr (rd_s1[RIDX_W-1:0]),
		.wdata (alu_reg_data),
		.re    (cmd_fire),
		.raddr (srcb_in[RIDX_W-1:0]),
		.rdata (ram_b)
	);

	// Data memory
	tce_ram #(.WIDTH(DATA_BITS), .DEPTH(MEM_WORDS)) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (alu_mem_addr[MADR_W-1:0]),
		.wdata (alu_mem_data),
		.re    (cmd_fire || s1_step),
		.raddr (m_rd_addr[MADR_W-1:0]),
		.rdata (ram_m)
	);

	// Resolve operands: out of range reads zero, last write forwards, unwritten reads zero
	always_comb begin
		if (int'(rd_s1) >= REG_COUNT) begin
			opa = '0;
		end else if (fwr_v_q && fwr_idx_q == rd_s1[RIDX_W-1:0]) begin
			opa = fwr_data_q;
		end else if (rvalid_q[rd_s1[RIDX_W-1:0]]) begin
			opa = ram_a;
		end else begin
			opa = '0;
		end

		if (int'(srcb_s1) >= REG_COUNT) begin
			opb = '0;
		end else if (fwr_v_q && fwr_idx_q == srcb_s1[RIDX_W-1:0]) begin
			opb = fwr_data_q;
		end else if (rvalid_q[srcb_s1[RIDX_W-1:0]]) begin
			opb = ram_b;
		end else begin
			opb = '0;
		end

		if (int'(maddr_s1) >= MEM_WORDS) begin
			mem_val = '0;
		end else if (fwm_v_q && fwm_addr_q == maddr_s1[MADR_W-1:0]) begin
			mem_val = fwm_data_q;
		end else if (mvalid_q[maddr_s1[MADR_W-1:0]]) begin
			mem_val = ram_m;
		end else begin
			mem_val = '0;
		end
	end

	tce_alu #(
		.REG_COUNT (REG_COUNT),
		.MEM_WORDS (MEM_WORDS),
		.DATA_BITS (DATA_BITS),
		.PC_BITS   (PC_BITS)
	) u_alu (
		.op        (op_s1),
		.rd        (rd_s1),
		.so        (so_s1),
		.pc        (pc_q),
		.opa       (opa),
		.opb       (opb),
		.mem_rdata (mem_val),
		.flags     (flags),
		.reg_data  (alu_reg_data),
		.st_addr   (alu_mem_addr),
		.mem_data  (alu_mem_data),
		.next_pc   (alu_next_pc)
	);

	// Execute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			ph_s1 <= 1'b0;
		end else if (cmd_fire) begin
			v_s1  <= 1'b1;
			ph_s1 <= 1'b0;
		end else if (s1_done) begin
			v_s1  <= 1'b0;
		end else if (s1_step) begin
			ph_s1 <= 1'b1;
		end
	end

	// Execute stage payload; hold the address of the data read in flight
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_s1    <= cmd.op;
			rd_s1    <= cmd.first_reg;
			srcb_s1  <= srcb_in;
			so_s1    <= cmd.second_operand;
			maddr_s1 <= cmd.second_operand[ADDR_W-1:0];
		end else if (s1_step) begin
			maddr_s1 <= opb[ADDR_W-1:0];
		end
	end

	// Commit: PC, valid bits and the most recent write of each memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			rvalid_q <= '0;
			mvalid_q <= '0;
			fwr_v_q  <= 1'b0;
			fwm_v_q  <= 1'b0;
		end else begin
			if (s1_done) begin
				pc_q <= alu_next_pc;
			end
			if (reg_we) begin
				rvalid_q[rd_s1[RIDX_W-1:0]] <= 1'b1;
				fwr_v_q                     <= 1'b1;
			end
			if (mem_we) begin
				mvalid_q[alu_mem_addr[MADR_W-1:0]] <= 1'b1;
				fwm_v_q                            <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (reg_we) begin
			fwr_idx_q  <= rd_s1[RIDX_W-1:0];
			fwr_data_q <= alu_reg_data;
		end
		if (mem_we) begin
			fwm_addr_q <= alu_mem_addr[MADR_W-1:0];
			fwm_data_q <= alu_mem_data;
		end
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_done) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			npc_q  <= NPC_W'(alu_next_pc);
			ill_q  <= flags.illegal;
			rwr_q  <= flags.reg_wr;
			rtgt_q <= flags.reg_wr ? rd_s1 : '0;
			rdat_q <= WORD_W'(signed'(alu_reg_data));
			mwr_q  <= flags.mem_wr;
			madr_q <= alu_mem_addr;
			mdat_q <= WORD_W'(signed'(alu_mem_data));
		end
	end

	assign res.valid       = out_v_q;
	assign res.next_pc     = npc_q;
	assign res.illegal     = ill_q;
	assign res.reg_write   = rwr_q;
	assign res.reg_target  = rtgt_q;
	assign res.reg_data    = rdat_q;
	assign res.mem_write   = mwr_q;
	assign res.mem_address = madr_q;
	assign res.mem_data    = mdat_q;

endmodule

`default_nettype wire

>>> design/tce_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Standalone; used for the register file copies and the data memory.
`default_nettype none

module tce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then read with old data on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/tce_alu.sv
// Instruction decode and datapath: register/memory results, store data and next PC.
// Depends on tce_pkg for opcodes and the status struct.
`default_nettype none

module tce_alu #(
	parameter int REG_COUNT = 16,
	parameter int MEM_WORDS = 256,
	parameter int DATA_BITS = 32,
	parameter int PC_BITS   = 16
) (
	input  wire logic [tce_pkg::OP_W-1:0]   op,
	input  wire logic [tce_pkg::IDX_W-1:0]  rd,
	input  wire logic [tce_pkg::WORD_W-1:0] so,
	input  wire logic [PC_BITS-1:0]         pc,
	input  wire logic [DATA_BITS-1:0]       opa,
	input  wire logic [DATA_BITS-1:0]       opb,
	input  wire logic [DATA_BITS-1:0]       mem_rdata,
	output tce_pkg::exec_flags_t            flags,
	output logic [DATA_BITS-1:0]            reg_data,
	output logic [tce_pkg::ADDR_W-1:0]      st_addr,
	output logic [DATA_BITS-1:0]            mem_data,
	output logic [PC_BITS-1:0]              next_pc
);
	import tce_pkg::*;

	logic                 reg_wr;
	logic                 mem_wr;
	logic                 illegal;
	logic                 reg_ok;
	logic                 mem_ok;
	logic [DATA_BITS-1:0] rval;
	logic [DATA_BITS-1:0] mval;
	logic [ADDR_W-1:0]    maddr;
	logic [PC_BITS-1:0]   pc_inc;

	// Decode and compute
	always_comb begin
		pc_inc  = pc + PC_BITS'(1);
		next_pc = pc_inc;
		rval    = '0;
		mval    = '0;
		maddr   = '0;
		reg_wr  = 1'b0;
		mem_wr  = 1'b0;
		illegal = 1'b0;
		unique case (op)
			OP_LD_DIR: begin
				reg_wr = 1'b1;
				rval   = mem_rdata;
			end
			OP_ST_DIR: begin
				mem_wr = 1'b1;
				maddr  = so[ADDR_W-1:0];
				mval   = opa;
			end
			OP_ST_IND: begin
				mem_wr = 1'b1;
				maddr  = opa[ADDR_W-1:0];
				mval   = opb;
			end
			OP_LD_IMM: begin
				reg_wr = 1'b1;
				rval   = so[DATA_BITS-1:0];
			end
			OP_COPY: begin
				reg_wr = 1'b1;
				rval   = opb;
			end
			OP_LD_IND: begin
				reg_wr = 1'b1;
				rval   = mem_rdata;
			end
			OP_ADD: begin
				reg_wr = 1'b1;
				rval   = opa + opb;
			end
			OP_SUB: begin
				reg_wr = 1'b1;
				rval   = opa - opb;
			end
			OP_MUL: begin
				reg_wr = 1'b1;
				rval   = opa * opb;
			end
			OP_JZ: begin
				if (opa == '0) begin
					next_pc = pc_inc + so[PC_BITS-1:0];
				end
			end
			default: begin
				illegal = 1'b1;
				next_pc = pc;
			end
		endcase
	end

	// Drop writes that fall outside the register file or the data memory
	assign reg_ok = reg_wr && (int'(rd) < REG_COUNT);
	assign mem_ok = mem_wr && (int'(maddr) < MEM_WORDS);

	assign flags.illegal = illegal;
	assign flags.reg_wr  = reg_ok;
	assign flags.mem_wr  = mem_ok;
	assign reg_data      = reg_ok ? rval : '0;
	assign st_addr       = mem_ok ? maddr : '0;
	assign mem_data      = mem_ok ? mval : '0;

endmodule

`default_nettype wire
